### hw/rtl/lhte_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lhte_pkg;

  // Table geometry
  localparam int MAX_BUCKETS = 256;
  localparam int SLOTS       = 16;
  localparam int TABLES      = 4;
  localparam int TW          = $clog2(TABLES);
  localparam int BW          = $clog2(MAX_BUCKETS);
  localparam int SW          = $clog2(SLOTS);
  localparam int CNT_W       = BW + 1;
  localparam int FILL_W      = SW + 1;
  localparam int ENT_W       = 13;
  localparam int LOAD_W      = 5;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_HIGH = 1'b0;
  localparam logic REG_LOW  = 1'b1;
  localparam logic [LOAD_W-1:0] HIGH_RST = 5'd4;
  localparam logic [LOAD_W-1:0] LOW_RST  = 5'd1;

  // Action codes
  localparam logic [3:0] ACT_FIND_FIRST   = 4'd0;
  localparam logic [3:0] ACT_FIND_NEXT    = 4'd1;
  localparam logic [3:0] ACT_INSERT       = 4'd2;
  localparam logic [3:0] ACT_DELETE       = 4'd3;
  localparam logic [3:0] ACT_LOCK         = 4'd4;
  localparam logic [3:0] ACT_UNLOCK       = 4'd5;
  localparam logic [3:0] ACT_SET_PAGE     = 4'd6;
  localparam logic [3:0] ACT_SET_PAGE_IDX = 4'd7;
  localparam logic [3:0] ACT_SET_OWNER    = 4'd8;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_LOCK   = 2'd2;
  localparam logic [1:0] ST_CURSOR = 2'd3;

  // Result kinds
  localparam logic KIND_ANSWER = 1'b0;
  localparam logic KIND_NOTICE = 1'b1;

  typedef struct packed {
    logic [3:0]  action;
    logic [31:0] key_hash;
    logic [7:0]  cursor_bucket;
    logic [3:0]  cursor_slot;
    logic [30:0] owner_ref;
    logic [31:0] page_number;
    logic [12:0] page_slot;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic        found;
    logic [7:0]  result_bucket;
    logic [3:0]  result_slot;
    logic        is_locked;
    logic [30:0] owner_out;
    logic [31:0] page_number_out;
    logic [12:0] page_slot_out;
    logic [1:0]  status;
    logic        last;
  } out_word_t;

  // One stored entry
  typedef struct packed {
    logic [31:0] hash;
    logic        locked;
    logic [30:0] owner;
    logic [31:0] page;
    logic [12:0] pidx;
  } slot_t;

  typedef struct packed {
    logic [LOAD_W-1:0] high;
    logic [LOAD_W-1:0] low;
  } cfg_t;

  // Sequencer to output stage
  typedef struct packed {
    logic      push;
    logic      close;
    out_word_t word;
  } emit_t;

  typedef struct packed {
    logic push_rdy;
    logic close_rdy;
  } emit_rdy_t;

  // Linear-hashing home bucket: widest low mask of u that lands below n.
  // Masks of 9 bits or more give the same value as the 8-bit mask.
  function automatic logic [BW-1:0] home_bucket(input logic [BW-1:0] u,
                                                input logic [CNT_W-1:0] n);
    logic [BW-1:0]    r;
    logic [CNT_W-1:0] m;
    r = '0;
    for (int k = 0; k <= BW; k++) begin
      m = (CNT_W'(1) << k) - CNT_W'(1);
      if (({1'b0, u} & m) < n) r = u & m[BW-1:0];
    end
    return r;
  endfunction

  // Clear the highest set bit
  function automatic logic [BW-1:0] sibling(input logic [BW-1:0] x);
    logic [BW-1:0] top;
    top = '0;
    for (int k = 0; k < BW; k++) begin
      if (x[k]) top = BW'(1) << k;
    end
    return x & ~top;
  endfunction

  function automatic out_word_t entry_word(input logic kind, input logic [BW-1:0] b,
                                           input logic [SW-1:0] s, input slot_t d,
                                           input logic [1:0] status);
    out_word_t w;
    w.kind            = kind;
    w.found           = 1'b1;
    w.result_bucket   = b;
    w.result_slot     = s;
    w.is_locked       = d.locked;
    w.owner_out       = d.locked ? d.owner : '0;
    w.page_number_out = d.page;
    w.page_slot_out   = d.pidx;
    w.status          = status;
    w.last            = 1'b0;
    return w;
  endfunction

  function automatic out_word_t miss_word(input logic [BW-1:0] b, input logic [SW-1:0] s,
                                          input logic [1:0] status);
    out_word_t w;
    w               = '0;
    w.kind          = KIND_ANSWER;
    w.result_bucket = b;
    w.result_slot   = s;
    w.status        = status;
    return w;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/lhte_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module lhte_regs (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [lhte_pkg::CFG_AW-1:0] paddr,
  input  wire logic [lhte_pkg::CFG_DW-1:0] pwdata,
  output logic      [lhte_pkg::CFG_DW-1:0] prdata,
  output logic                           pready,
  output lhte_pkg::cfg_t                 cfg
);
  import lhte_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr;
  logic idx;

  assign idx    = paddr[2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Register write
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      if (idx == REG_HIGH) cfg_nxt.high = pwdata[LOAD_W-1:0];
      else                 cfg_nxt.low  = pwdata[LOAD_W-1:0];
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    if (idx == REG_HIGH) prdata[LOAD_W-1:0] = cfg_r.high;
    else                 prdata[LOAD_W-1:0] = cfg_r.low;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.high <= HIGH_RST;
      cfg_r.low  <= LOW_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/lhte_out.sv
`timescale 1ns / 1ps
`default_nettype none

// Holds one word back so the final word of an item can be marked last,
// then registers it onto the result channel.
module lhte_out (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire lhte_pkg::emit_t      ctl,
  output lhte_pkg::emit_rdy_t       rdy,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output lhte_pkg::out_word_t       out_word
);
  import lhte_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r, out_word_nxt;
  logic      pend_v_r, pend_v_nxt;
  out_word_t pend_r, pend_nxt;
  logic      out_free;

  assign out_free      = !out_valid_r || !out_stall;
  assign rdy.push_rdy  = !pend_v_r || out_free;
  assign rdy.close_rdy = out_free;
  assign out_valid     = out_valid_r;
  assign out_word      = out_word_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    if (out_free) out_valid_nxt = 1'b0;
    if (ctl.close && out_free) begin
      // final word of the item
      out_word_nxt      = pend_r;
      out_word_nxt.last = 1'b1;
      out_valid_nxt     = 1'b1;
      pend_v_nxt        = 1'b0;
    end else if (ctl.push && rdy.push_rdy) begin
      if (pend_v_r) begin
        out_word_nxt      = pend_r;
        out_word_nxt.last = 1'b0;
        out_valid_nxt     = 1'b1;
      end
      pend_nxt   = ctl.word;
      pend_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    pend_r     <= pend_nxt;
  end

  a_push_close_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.push && ctl.close))
    else $error("push and close in the same cycle");

  a_close_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.close |-> pend_v_r)
    else $error("close without a held word");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(ctl.push) || $past(ctl.close)))
    else $error("result word appeared without a push or close");

endmodule

`default_nettype wire

### hw/rtl/lhte_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

// Sequencer around the bucket fill memory and the slot memory.
module lhte_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire lhte_pkg::in_word_t  in_word,
  input  wire lhte_pkg::cfg_t      cfg,
  output lhte_pkg::emit_t          emit,
  input  wire lhte_pkg::emit_rdy_t rdy
);
  import lhte_pkg::*;

  localparam int FA_W       = TW + BW;
  localparam int SA_W       = FA_W + SW;
  localparam int FILL_DEPTH = TABLES * MAX_BUCKETS;
  localparam int SLOT_DEPTH = FILL_DEPTH * SLOTS;
  localparam int LD_W       = CNT_W + LOAD_W;

  typedef enum logic [22:0] {
    S_CLEAR  = 23'h000001,
    S_IDLE   = 23'h000002,
    S_HOME   = 23'h000004,
    S_FILL   = 23'h000008,
    S_SLOT   = 23'h000010,
    S_SRD    = 23'h000020,
    S_SCK    = 23'h000040,
    S_NRD    = 23'h000080,
    S_NCK    = 23'h000100,
    S_GROW   = 23'h000200,
    S_SPF    = 23'h000400,
    S_SPR    = 23'h000800,
    S_SPW    = 23'h001000,
    S_SPE    = 23'h002000,
    S_SHRINK = 23'h004000,
    S_MF1    = 23'h008000,
    S_MF2    = 23'h010000,
    S_MR     = 23'h020000,
    S_MW     = 23'h040000,
    S_MFE    = 23'h080000,
    S_DRD    = 23'h100000,
    S_DWR    = 23'h200000,
    S_FIN    = 23'h400000
  } state_t;

  // What follows a notice scan
  typedef enum logic [2:0] {
    PH_INS      = 3'd0,
    PH_DEL      = 3'd1,
    PH_SPLIT_OD = 3'd2,
    PH_SPLIT_NW = 3'd3,
    PH_MERGE    = 3'd4
  } phase_t;

  state_t             state_r, state_nxt;
  phase_t             ph_r, ph_nxt;
  logic [FA_W-1:0]    clr_r, clr_nxt;
  in_word_t           req_r, req_nxt;
  logic [BW-1:0]      b_r, b_nxt, od_r, od_nxt, nw_r, nw_nxt, nb_r, nb_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt, s_r, s_nxt, k_r, k_nxt, cnt_r, cnt_nxt;
  logic [FILL_W-1:0]  jo_r, jo_nxt, jn_r, jn_nxt, fnw_r, fnw_nxt, nf_r, nf_nxt;
  logic [CNT_W-1:0]   bcnt_r [TABLES];
  logic [CNT_W-1:0]   bcnt_nxt [TABLES];
  logic [ENT_W-1:0]   ecnt_r [TABLES];
  logic [ENT_W-1:0]   ecnt_nxt [TABLES];

  // Memories
  logic [FILL_W-1:0]  fill_mem [FILL_DEPTH];
  slot_t              slot_mem [SLOT_DEPTH];
  logic [FILL_W-1:0]  fill_rd_r;
  slot_t              slot_rd_r;
  logic               fill_re, fill_we, slot_re, slot_we;
  logic [FA_W-1:0]    fill_raddr, fill_waddr;
  logic [FILL_W-1:0]  fill_wdata;
  logic [SA_W-1:0]    slot_raddr, slot_waddr;
  slot_t              slot_wdata;

  // Helpers
  logic [TW-1:0]      t;
  logic [CNT_W-1:0]   bcnt;
  logic [ENT_W-1:0]   ecnt;
  logic [BW-1:0]      home_b, grow_nw, shr_od, spl_home;
  logic [LD_W-1:0]    hi_ld, lo_ld;
  slot_t              ins_slot, md;
  logic [1:0]         mst;
  logic [FILL_W:0]    mrg_sum;
  logic               cnt_ok;

  assign t        = req_r.key_hash[TW-1:0];
  assign bcnt     = bcnt_r[t];
  assign ecnt     = ecnt_r[t];
  assign home_b   = home_bucket(req_r.key_hash[BW+1:2], bcnt);
  assign grow_nw  = bcnt[BW-1:0];
  assign shr_od   = BW'(bcnt - CNT_W'(1));
  assign spl_home = home_bucket(slot_rd_r.hash[BW+1:2], {1'b0, nw_r} + CNT_W'(1));
  assign hi_ld    = LD_W'(bcnt) * LD_W'(cfg.high);
  assign lo_ld    = LD_W'(bcnt) * LD_W'(cfg.low);
  assign mrg_sum  = {1'b0, cnt_r} + {1'b0, fill_rd_r};
  assign in_stall = (state_r != S_IDLE);

  assign ins_slot = '{hash: req_r.key_hash, locked: 1'b1, owner: req_r.owner_ref,
                      page: req_r.page_number, pidx: req_r.page_slot};

  // Field update for lock, unlock and set actions
  always_comb begin
    md  = slot_rd_r;
    mst = ST_OK;
    case (req_r.action)
      ACT_LOCK: begin
        if (slot_rd_r.locked) mst = ST_LOCK;
        else begin
          md.locked = 1'b1;
          md.owner  = req_r.owner_ref;
        end
      end
      ACT_UNLOCK: begin
        if (!slot_rd_r.locked) mst = ST_LOCK;
        else begin
          md.locked = 1'b0;
          md.owner  = '0;
        end
      end
      ACT_SET_PAGE: md.page = req_r.page_number;
      ACT_SET_PAGE_IDX: begin
        if (!slot_rd_r.locked) mst = ST_LOCK;
        else begin
          md.page = req_r.page_number;
          md.pidx = req_r.page_slot;
        end
      end
      ACT_SET_OWNER: begin
        if (!slot_rd_r.locked) mst = ST_LOCK;
        else begin
          md.locked = 1'b1;
          md.owner  = req_r.owner_ref;
        end
      end
      default: md = slot_rd_r;
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    clr_nxt   = clr_r;
    req_nxt   = req_r;
    b_nxt     = b_r;
    od_nxt    = od_r;
    nw_nxt    = nw_r;
    nb_nxt    = nb_r;
    fill_nxt  = fill_r;
    s_nxt     = s_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    jo_nxt    = jo_r;
    jn_nxt    = jn_r;
    fnw_nxt   = fnw_r;
    nf_nxt    = nf_r;
    bcnt_nxt  = bcnt_r;
    ecnt_nxt  = ecnt_r;
    fill_re    = 1'b0;
    fill_raddr = '0;
    fill_we    = 1'b0;
    fill_waddr = '0;
    fill_wdata = '0;
    slot_re    = 1'b0;
    slot_raddr = '0;
    slot_we    = 1'b0;
    slot_waddr = '0;
    slot_wdata = slot_rd_r;
    emit.push  = 1'b0;
    emit.close = 1'b0;
    emit.word  = '0;

    case (state_r)
      S_CLEAR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_r;
        clr_nxt    = clr_r + FA_W'(1);
        if (clr_r == '1) state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_word;
          state_nxt = S_HOME;
        end
      end

      S_HOME: begin
        if (req_r.action > ACT_SET_OWNER) begin
          emit.push = 1'b1;
          emit.word = miss_word('0, '0, ST_OK);
          if (rdy.push_rdy) state_nxt = S_FIN;
        end else if (req_r.action == ACT_FIND_FIRST || req_r.action == ACT_INSERT) begin
          b_nxt      = home_b;
          fill_re    = 1'b1;
          fill_raddr = {t, home_b};
          state_nxt  = S_FILL;
        end else if ({1'b0, req_r.cursor_bucket} >= bcnt) begin
          emit.push = 1'b1;
          emit.word = miss_word(req_r.cursor_bucket, req_r.cursor_slot, ST_CURSOR);
          if (rdy.push_rdy) state_nxt = S_FIN;
        end else begin
          b_nxt      = req_r.cursor_bucket;
          fill_re    = 1'b1;
          fill_raddr = {t, req_r.cursor_bucket};
          state_nxt  = S_FILL;
        end
      end

      S_FILL: begin
        fill_nxt = fill_rd_r;
        if (req_r.action == ACT_FIND_FIRST) begin
          s_nxt     = '0;
          state_nxt = S_SRD;
        end else if (req_r.action == ACT_INSERT) begin
          emit.push = 1'b1;
          if (fill_rd_r >= FILL_W'(SLOTS)) begin
            emit.word = miss_word(b_r, '0, ST_FULL);
            if (rdy.push_rdy) state_nxt = S_FIN;
          end else begin
            emit.word = entry_word(KIND_ANSWER, b_r, fill_rd_r[SW-1:0], ins_slot, ST_OK);
            if (rdy.push_rdy) begin
              slot_we     = 1'b1;
              slot_waddr  = {t, b_r, fill_rd_r[SW-1:0]};
              slot_wdata  = ins_slot;
              fill_we     = 1'b1;
              fill_waddr  = {t, b_r};
              fill_wdata  = fill_rd_r + FILL_W'(1);
              ecnt_nxt[t] = ecnt + ENT_W'(1);
              nb_nxt      = b_r;
              nf_nxt      = fill_rd_r + FILL_W'(1);
              s_nxt       = '0;
              ph_nxt      = PH_INS;
              state_nxt   = S_NRD;
            end
          end
        end else if ({1'b0, req_r.cursor_slot} >= fill_rd_r) begin
          emit.push = 1'b1;
          emit.word = miss_word(req_r.cursor_bucket, req_r.cursor_slot, ST_CURSOR);
          if (rdy.push_rdy) state_nxt = S_FIN;
        end else begin
          slot_re    = 1'b1;
          slot_raddr = {t, b_r, req_r.cursor_slot};
          state_nxt  = S_SLOT;
        end
      end

      S_SLOT: begin
        if (slot_rd_r.hash != req_r.key_hash) begin
          emit.push = 1'b1;
          emit.word = miss_word(req_r.cursor_bucket, req_r.cursor_slot, ST_CURSOR);
          if (rdy.push_rdy) state_nxt = S_FIN;
        end else if (req_r.action == ACT_FIND_NEXT) begin
          s_nxt     = {1'b0, req_r.cursor_slot} + FILL_W'(1);
          state_nxt = S_SRD;
        end else if (req_r.action == ACT_DELETE) begin
          emit.push = 1'b1;
          emit.word = entry_word(KIND_ANSWER, b_r, req_r.cursor_slot, slot_rd_r, ST_OK);
          if (rdy.push_rdy) begin
            k_nxt     = {1'b0, req_r.cursor_slot};
            state_nxt = S_DRD;
          end
        end else begin
          emit.push = 1'b1;
          emit.word = entry_word(KIND_ANSWER, b_r, req_r.cursor_slot, md, mst);
          if (rdy.push_rdy) begin
            slot_we    = 1'b1;
            slot_waddr = {t, b_r, req_r.cursor_slot};
            slot_wdata = md;
            state_nxt  = S_FIN;
          end
        end
      end

      // search scan: read a slot in S_SRD, compare its hash in S_SCK
      S_SRD: begin
        if (s_r < fill_r) begin
          slot_re    = 1'b1;
          slot_raddr = {t, b_r, s_r[SW-1:0]};
          state_nxt  = S_SCK;
        end else begin
          emit.push = 1'b1;
          if (fill_r >= FILL_W'(SLOTS)) emit.word = miss_word(b_r, '0, ST_FULL);
          else                          emit.word = miss_word(b_r, fill_r[SW-1:0], ST_OK);
          if (rdy.push_rdy) state_nxt = S_FIN;
        end
      end

      S_SCK: begin
        if (slot_rd_r.hash == req_r.key_hash) begin
          emit.push = 1'b1;
          emit.word = entry_word(KIND_ANSWER, b_r, s_r[SW-1:0], slot_rd_r, ST_OK);
          if (rdy.push_rdy) state_nxt = S_FIN;
        end else begin
          s_nxt     = s_r + FILL_W'(1);
          state_nxt = S_SRD;
        end
      end

      // relocation notices for locked entries of bucket nb
      S_NRD: begin
        if (s_r < nf_r) begin
          slot_re    = 1'b1;
          slot_raddr = {t, nb_r, s_r[SW-1:0]};
          state_nxt  = S_NCK;
        end else begin
          case (ph_r)
            PH_INS: state_nxt = S_GROW;
            PH_DEL: state_nxt = S_SHRINK;
            PH_SPLIT_OD: begin
              nb_nxt = nw_r;
              nf_nxt = jn_r;
              s_nxt  = '0;
              ph_nxt = PH_SPLIT_NW;
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end

      S_NCK: begin
        if (slot_rd_r.locked) begin
          emit.push = 1'b1;
          emit.word = entry_word(KIND_NOTICE, nb_r, s_r[SW-1:0], slot_rd_r, ST_OK);
          if (rdy.push_rdy) begin
            s_nxt     = s_r + FILL_W'(1);
            state_nxt = S_NRD;
          end
        end else begin
          s_nxt     = s_r + FILL_W'(1);
          state_nxt = S_NRD;
        end
      end

      // split: bucket od spreads over od and the new bucket nw
      S_GROW: begin
        if (bcnt < CNT_W'(MAX_BUCKETS) && {1'b0, ecnt} > LD_W'(hi_ld)) begin
          nw_nxt      = grow_nw;
          od_nxt      = sibling(grow_nw);
          bcnt_nxt[t] = bcnt + CNT_W'(1);
          fill_re     = 1'b1;
          fill_raddr  = {t, sibling(grow_nw)};
          state_nxt   = S_SPF;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_SPF: begin
        cnt_nxt   = fill_rd_r;
        k_nxt     = '0;
        jo_nxt    = '0;
        jn_nxt    = '0;
        state_nxt = S_SPR;
      end

      S_SPR: begin
        if (k_r < cnt_r) begin
          slot_re    = 1'b1;
          slot_raddr = {t, od_r, k_r[SW-1:0]};
          state_nxt  = S_SPW;
        end else begin
          fill_we    = 1'b1;
          fill_waddr = {t, od_r};
          fill_wdata = jo_r;
          state_nxt  = S_SPE;
        end
      end

      S_SPW: begin
        slot_we = 1'b1;
        if (spl_home == nw_r) begin
          slot_waddr = {t, nw_r, jn_r[SW-1:0]};
          jn_nxt     = jn_r + FILL_W'(1);
        end else begin
          slot_waddr = {t, od_r, jo_r[SW-1:0]};
          jo_nxt     = jo_r + FILL_W'(1);
        end
        k_nxt     = k_r + FILL_W'(1);
        state_nxt = S_SPR;
      end

      S_SPE: begin
        fill_we    = 1'b1;
        fill_waddr = {t, nw_r};
        fill_wdata = jn_r;
        nb_nxt     = od_r;
        nf_nxt     = jo_r;
        s_nxt      = '0;
        ph_nxt     = PH_SPLIT_OD;
        state_nxt  = S_NRD;
      end

      // merge: last bucket od folds into its sibling nw
      S_SHRINK: begin
        if (bcnt > CNT_W'(1) && {1'b0, ecnt} < LD_W'(lo_ld)) begin
          od_nxt     = shr_od;
          nw_nxt     = sibling(shr_od);
          fill_re    = 1'b1;
          fill_raddr = {t, shr_od};
          state_nxt  = S_MF1;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_MF1: begin
        cnt_nxt    = fill_rd_r;
        fill_re    = 1'b1;
        fill_raddr = {t, nw_r};
        state_nxt  = S_MF2;
      end

      S_MF2: begin
        fnw_nxt = fill_rd_r;
        k_nxt   = '0;
        if (mrg_sum > (FILL_W + 1)'(SLOTS)) state_nxt = S_FIN;
        else                                state_nxt = S_MR;
      end

      S_MR: begin
        if (k_r < cnt_r) begin
          slot_re    = 1'b1;
          slot_raddr = {t, od_r, k_r[SW-1:0]};
          state_nxt  = S_MW;
        end else begin
          fill_we    = 1'b1;
          fill_waddr = {t, od_r};
          fill_wdata = '0;
          state_nxt  = S_MFE;
        end
      end

      S_MW: begin
        slot_we    = 1'b1;
        slot_waddr = {t, nw_r, SW'(fnw_r + k_r)};
        k_nxt      = k_r + FILL_W'(1);
        state_nxt  = S_MR;
      end

      S_MFE: begin
        fill_we     = 1'b1;
        fill_waddr  = {t, nw_r};
        fill_wdata  = fnw_r + cnt_r;
        bcnt_nxt[t] = bcnt - CNT_W'(1);
        nb_nxt      = nw_r;
        nf_nxt      = fnw_r + cnt_r;
        s_nxt       = '0;
        ph_nxt      = PH_MERGE;
        state_nxt   = S_NRD;
      end

      // delete: close the gap, reading the next slot in S_DRD and writing it one place down in S_DWR
      S_DRD: begin
        if (k_r + FILL_W'(1) < fill_r) begin
          slot_re    = 1'b1;
          slot_raddr = {t, b_r, SW'(k_r + FILL_W'(1))};
          state_nxt  = S_DWR;
        end else begin
          fill_we    = 1'b1;
          fill_waddr = {t, b_r};
          fill_wdata = fill_r - FILL_W'(1);
          if (ecnt != '0) ecnt_nxt[t] = ecnt - ENT_W'(1);
          nb_nxt     = b_r;
          nf_nxt     = fill_r - FILL_W'(1);
          s_nxt      = '0;
          ph_nxt     = PH_DEL;
          state_nxt  = S_NRD;
        end
      end

      S_DWR: begin
        slot_we    = 1'b1;
        slot_waddr = {t, b_r, k_r[SW-1:0]};
        k_nxt      = k_r + FILL_W'(1);
        state_nxt  = S_DRD;
      end

      S_FIN: begin
        emit.close = 1'b1;
        if (rdy.close_rdy) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      for (int i = 0; i < TABLES; i++) begin
        bcnt_r[i] <= CNT_W'(1);
        ecnt_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      bcnt_r  <= bcnt_nxt;
      ecnt_r  <= ecnt_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    ph_r   <= ph_nxt;
    req_r  <= req_nxt;
    b_r    <= b_nxt;
    od_r   <= od_nxt;
    nw_r   <= nw_nxt;
    nb_r   <= nb_nxt;
    fill_r <= fill_nxt;
    s_r    <= s_nxt;
    k_r    <= k_nxt;
    cnt_r  <= cnt_nxt;
    jo_r   <= jo_nxt;
    jn_r   <= jn_nxt;
    fnw_r  <= fnw_nxt;
    nf_r   <= nf_nxt;
  end

  // Fill memory
  always_ff @(posedge clk) begin
    if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
    if (fill_re) fill_rd_r <= fill_mem[fill_raddr];
  end

  // Slot memory
  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    if (slot_re) slot_rd_r <= slot_mem[slot_raddr];
  end

  always_comb begin
    cnt_ok = 1'b1;
    for (int i = 0; i < TABLES; i++) begin
      if (bcnt_r[i] == '0 || bcnt_r[i] > CNT_W'(MAX_BUCKETS)) cnt_ok = 1'b0;
    end
  end

  a_bucket_count_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_ok)
    else $error("bucket count out of range");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_we |-> (fill_wdata <= FILL_W'(SLOTS)))
    else $error("bucket fill above slot count");

  a_slot_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    slot_we |-> (state_r == S_FILL || state_r == S_SLOT || state_r == S_SPW ||
                 state_r == S_MW || state_r == S_DWR))
    else $error("slot write outside a data-moving step");

endmodule

`default_nettype wire

### hw/rtl/linear_hash_table_engine_core.sv
// Linear-hash table engine: four tables, picked by key_hash[1:0], of up to 256
// buckets of 16 slots each, holding key hashes with lock, owner and page fields.
// Each input word gives one answer word, then relocation notices for locked
// entries of every bucket that changed; the last word of an item carries last.
// An item runs one at a time through a sequencer over a slot memory and a bucket
// fill memory, each with a read port and a write port. A search or a notice pass
// reads and checks each slot in turn, a delete shifts each later slot down one place
// and a split or merge moves each entry; a stall on the result side holds it.
// After reset the fill memory is cleared, all 1024 entries, in a pass during which
// no input word is taken; configuration writes are accepted throughout and take
// effect at once, so write them between items.
`timescale 1ns / 1ps
`default_nettype none

module linear_hash_table_engine_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire lhte_pkg::in_word_t          in_word,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output lhte_pkg::out_word_t              out_word,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lhte_pkg::CFG_AW-1:0] paddr,
  input  wire logic [lhte_pkg::CFG_DW-1:0] pwdata,
  output logic      [lhte_pkg::CFG_DW-1:0] prdata,
  output logic                             pready
);
  import lhte_pkg::*;

  cfg_t      cfg;
  emit_t     emit;
  emit_rdy_t rdy;

  lhte_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lhte_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .cfg      (cfg),
    .emit     (emit),
    .rdy      (rdy)
  );

  lhte_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (emit),
    .rdy       (rdy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

### test/lhte_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the config port, keeps a shadow of the hash
// tables and compares every result word with the expected one.
module lhte_checker
  import lhte_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  in_word_t         in_word,
  input  logic             out_valid,
  input  logic             out_stall,
  input  out_word_t        out_word,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  input  logic             pready,
  output int               errors,
  output int               pending
);

  localparam int NBUCK = TABLES * MAX_BUCKETS;

  // Shadow state
  logic [LOAD_W-1:0] hi_load, lo_load;
  int unsigned       bcnt [TABLES];
  int unsigned       ecnt [TABLES];
  int unsigned       fill [NBUCK];
  slot_t             mem  [NBUCK * SLOTS];
  out_word_t         exp_q[$];

  function automatic int bi(int t, int b);
    return t * MAX_BUCKETS + b;
  endfunction

  function automatic int si(int t, int b, int s);
    return bi(t, b) * SLOTS + s;
  endfunction

  // Mask the upper hash down until it lies below the bucket count
  function automatic int home_of(logic [31:0] h, int unsigned n);
    logic [31:0] u, m;
    u = h >> 2;
    m = 32'h3fff_ffff;
    while ((u & m) >= n && m != 0) m = m >> 1;
    return int'(u & m);
  endfunction

  // Clear the highest set bit
  function automatic int sib_of(int x);
    for (int k = 31; k >= 0; k--) begin
      if (x[k]) return x & ~(1 << k);
    end
    return x;
  endfunction

  // Position of an entry with this hash in its home bucket, for stimulus
  function automatic bit locate(input logic [31:0] h, input bit first_only,
                                output logic [7:0] b, output logic [3:0] s);
    int t, hb;
    int hits[$];
    t  = h[1:0];
    hb = home_of(h, bcnt[t]);
    b  = hb[7:0];
    s  = '0;
    for (int k = 0; k < fill[bi(t, hb)]; k++) begin
      if (mem[si(t, hb, k)].hash == h) hits.push_back(k);
    end
    if (hits.size() == 0) return 1'b0;
    if (first_only) s = hits[0][3:0];
    else s = hits[$urandom_range(hits.size() - 1)][3:0];
    return 1'b1;
  endfunction

  task automatic push_entry(logic kind, int t, int b, int s, logic [1:0] st);
    slot_t     d;
    out_word_t w;
    d = mem[si(t, b, s)];
    w = '0;
    w.kind            = kind;
    w.found           = 1'b1;
    w.result_bucket   = b[7:0];
    w.result_slot     = s[3:0];
    w.is_locked       = d.locked;
    w.owner_out       = d.locked ? d.owner : '0;
    w.page_number_out = d.page;
    w.page_slot_out   = d.pidx;
    w.status          = st;
    exp_q.push_back(w);
  endtask

  task automatic push_miss(int b, int s, logic [1:0] st);
    out_word_t w;
    w = '0;
    w.kind          = KIND_ANSWER;
    w.result_bucket = b[7:0];
    w.result_slot   = s[3:0];
    w.status        = st;
    exp_q.push_back(w);
  endtask

  // Relocation notices for every locked entry of a bucket
  task automatic notices(int t, int b);
    for (int s = 0; s < fill[bi(t, b)]; s++) begin
      if (mem[si(t, b, s)].locked) push_entry(KIND_NOTICE, t, b, s, ST_OK);
    end
  endtask

  task automatic search(int t, int b, int start, logic [31:0] h);
    int f;
    f = fill[bi(t, b)];
    for (int s = start; s < f; s++) begin
      if (mem[si(t, b, s)].hash == h) begin
        push_entry(KIND_ANSWER, t, b, s, ST_OK);
        return;
      end
    end
    if (f >= SLOTS) push_miss(b, 0, ST_FULL);
    else push_miss(b, f, ST_OK);
  endtask

  task automatic put(int t, int b, slot_t d);
    int f;
    f = fill[bi(t, b)];
    if (f >= SLOTS) return;
    mem[si(t, b, f)] = d;
    fill[bi(t, b)]   = f + 1;
  endtask

  task automatic split(int t);
    slot_t tmp[SLOTS];
    int    nw, od, cnt, d;
    nw  = bcnt[t];
    od  = sib_of(nw);
    cnt = fill[bi(t, od)];
    for (int k = 0; k < cnt; k++) tmp[k] = mem[si(t, od, k)];
    bcnt[t]         = nw + 1;
    fill[bi(t, od)] = 0;
    fill[bi(t, nw)] = 0;
    for (int k = 0; k < cnt; k++) begin
      d = home_of(tmp[k].hash, nw + 1);
      if (d != nw) d = od;
      put(t, d, tmp[k]);
    end
    notices(t, od);
    notices(t, nw);
  endtask

  task automatic merge(int t);
    int od, nw, cnt;
    od  = bcnt[t] - 1;
    nw  = sib_of(od);
    cnt = fill[bi(t, od)];
    // deferred when the sibling cannot take it all
    if (cnt + fill[bi(t, nw)] > SLOTS) return;
    for (int k = 0; k < cnt; k++) put(t, nw, mem[si(t, od, k)]);
    fill[bi(t, od)] = 0;
    bcnt[t]         = od;
    notices(t, nw);
  endtask

  // Expected words for one accepted input word
  task automatic predict(in_word_t w);
    int    t, b, f, cb, cs, i;
    logic [1:0] st;
    slot_t d;
    t  = w.key_hash[1:0];
    cb = w.cursor_bucket;
    cs = w.cursor_slot;
    if (w.action == ACT_FIND_FIRST) begin
      search(t, home_of(w.key_hash, bcnt[t]), 0, w.key_hash);
    end else if (w.action == ACT_INSERT) begin
      b = home_of(w.key_hash, bcnt[t]);
      f = fill[bi(t, b)];
      if (f >= SLOTS) begin
        push_miss(b, 0, ST_FULL);
      end else begin
        d.hash   = w.key_hash;
        d.locked = 1'b1;
        d.owner  = w.owner_ref;
        d.page   = w.page_number;
        d.pidx   = w.page_slot;
        put(t, b, d);
        ecnt[t]++;
        push_entry(KIND_ANSWER, t, b, f, ST_OK);
        notices(t, b);
        if (bcnt[t] < MAX_BUCKETS && ecnt[t] > bcnt[t] * hi_load) split(t);
      end
    end else if (w.action <= ACT_SET_OWNER) begin
      if (!(cb < bcnt[t] && cs < fill[bi(t, cb)] &&
            mem[si(t, cb, cs)].hash == w.key_hash)) begin
        push_miss(cb, cs, ST_CURSOR);
      end else begin
        i  = si(t, cb, cs);
        st = ST_OK;
        if (w.action == ACT_FIND_NEXT) begin
          search(t, cb, cs + 1, w.key_hash);
        end else if (w.action == ACT_DELETE) begin
          f = fill[bi(t, cb)];
          push_entry(KIND_ANSWER, t, cb, cs, ST_OK);
          for (int k = cs; k + 1 < f; k++) mem[si(t, cb, k)] = mem[si(t, cb, k + 1)];
          fill[bi(t, cb)] = f - 1;
          if (ecnt[t] > 0) ecnt[t]--;
          notices(t, cb);
          if (bcnt[t] > 1 && ecnt[t] < bcnt[t] * lo_load) merge(t);
        end else begin
          case (w.action)
            ACT_LOCK: begin
              if (mem[i].locked) st = ST_LOCK;
              else begin
                mem[i].locked = 1'b1;
                mem[i].owner  = w.owner_ref;
              end
            end
            ACT_UNLOCK: begin
              if (!mem[i].locked) st = ST_LOCK;
              else begin
                mem[i].locked = 1'b0;
                mem[i].owner  = '0;
              end
            end
            ACT_SET_PAGE: mem[i].page = w.page_number;
            ACT_SET_PAGE_IDX: begin
              if (!mem[i].locked) st = ST_LOCK;
              else begin
                mem[i].page = w.page_number;
                mem[i].pidx = w.page_slot;
              end
            end
            default: begin
              if (!mem[i].locked) st = ST_LOCK;
              else mem[i].owner = w.owner_ref;
            end
          endcase
          push_entry(KIND_ANSWER, t, cb, cs, st);
        end
      end
    end else begin
      push_miss(0, 0, ST_OK);
    end
    exp_q[exp_q.size() - 1].last = 1'b1;
  endtask

  task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s expected %0h got %0h", $time, name, e, a);
      errors++;
    end
  endtask

  // Channel monitor
  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      hi_load = HIGH_RST;
      lo_load = LOW_RST;
      for (int t = 0; t < TABLES; t++) begin
        bcnt[t] = 1;
        ecnt[t] = 0;
      end
      for (int k = 0; k < NBUCK; k++) fill[k] = 0;
      exp_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == {REG_HIGH, 2'b00}) hi_load = pwdata[LOAD_W-1:0];
        else if (paddr == {REG_LOW, 2'b00}) lo_load = pwdata[LOAD_W-1:0];
      end
      if (in_valid && !in_stall) predict(in_word);
      if (out_valid && !out_stall) begin
        if (exp_q.size() == 0) begin
          $display("%0t: unexpected word, expected none got %h", $time, out_word);
          errors++;
        end else begin
          e = exp_q.pop_front();
          check_field("kind", e.kind, out_word.kind);
          check_field("found", e.found, out_word.found);
          check_field("result_bucket", e.result_bucket, out_word.result_bucket);
          check_field("result_slot", e.result_slot, out_word.result_slot);
          check_field("is_locked", e.is_locked, out_word.is_locked);
          check_field("owner_out", e.owner_out, out_word.owner_out);
          check_field("page_number_out", e.page_number_out, out_word.page_number_out);
          check_field("page_slot_out", e.page_slot_out, out_word.page_slot_out);
          check_field("status", e.status, out_word.status);
          check_field("last", e.last, out_word.last);
        end
      end
    end
    pending <= exp_q.size();
  end

endmodule

### test/tb_linear_hash_table_engine_core.sv
`timescale 1ns / 1ps

module tb_linear_hash_table_engine_core;
  import lhte_pkg::*;

  localparam int LIMIT = 1000000;
  localparam int DRAIN = 200;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_word_t          in_word = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_word_t         out_word;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;
  int                errors;
  int                pending;
  int                cycles = 0;
  logic [31:0]       pool[32];

  linear_hash_table_engine_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  lhte_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side stall: mode picked by cycles[9:8]
  always @(posedge clk) begin
    case (cycles[9:8])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(3) == 0);
      2'd2: out_stall <= ($urandom_range(9) < 7);
      default: out_stall <= (cycles[2:0] < 3);
    endcase
  end

  function automatic in_word_t rand_fields(in_word_t w);
    w.owner_ref   = 31'($urandom());
    w.page_number = $urandom();
    w.page_slot   = 13'($urandom());
    return w;
  endfunction

  function automatic in_word_t aim(in_word_t w, bit first_only);
    logic [7:0] b;
    logic [3:0] s;
    if (u_chk.locate(w.key_hash, first_only, b, s)) begin
      w.cursor_bucket = b;
      w.cursor_slot   = s;
    end
    return w;
  endfunction

  // Opening sequence: field extremes, every action and the lock errors
  function automatic in_word_t dir_basic(int i);
    in_word_t w;
    w = '0;
    w.key_hash = 32'h0000_0011;
    case (i)
      0: begin
        w = '1;
        w.action = 4'hf;
      end
      1: w.action = ACT_FIND_FIRST;
      2: begin
        w = '1;
        w.action = ACT_INSERT;
        w.key_hash = 32'h0000_0011;
      end
      3: w.action = ACT_INSERT;
      4: begin
        w.action = ACT_INSERT;
        w.key_hash = 32'h4000_0011;
      end
      5: w.action = ACT_FIND_FIRST;
      6: w.action = ACT_FIND_NEXT;
      7: w.action = ACT_LOCK;
      8: w.action = ACT_UNLOCK;
      9: w.action = ACT_UNLOCK;
      10: w.action = ACT_SET_PAGE_IDX;
      11: w.action = ACT_SET_OWNER;
      12: begin
        w.action = ACT_SET_PAGE;
        w.page_number = 32'h5a5a_a5a5;
      end
      13: begin
        w.action = ACT_LOCK;
        w.owner_ref = 31'h0123_4567;
      end
      14: begin
        w.action = ACT_SET_OWNER;
        w.owner_ref = 31'h7fff_ffff;
      end
      15: begin
        w.action = ACT_SET_PAGE_IDX;
        w.page_slot = 13'h1fff;
      end
      16: begin
        w.action = ACT_DELETE;
        w.key_hash = 32'h4000_0011;
      end
      17: begin
        // cursor past the table
        w.action = ACT_DELETE;
        w.cursor_bucket = 8'hff;
        w.cursor_slot = 4'hf;
      end
      18: w.action = ACT_DELETE;
      default: w.action = 4'd9;
    endcase
    if (i >= 6 && i <= 16 || i == 18) w = aim(w, 1'b1);
    return w;
  endfunction

  // Fill bucket 0 of table 2 until it refuses, then miss on it
  function automatic in_word_t dir_full(int i);
    in_word_t w;
    w = rand_fields('0);
    if (i < 17) begin
      w.action = ACT_INSERT;
      w.key_hash = 32'h4000_0002;
    end else begin
      w.action = ACT_FIND_FIRST;
      w.key_hash = 32'h0000_0002;
    end
    return w;
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    int r;
    logic [3:0] acts[7];
    acts = '{ACT_FIND_NEXT, ACT_DELETE, ACT_LOCK, ACT_UNLOCK, ACT_SET_PAGE,
             ACT_SET_PAGE_IDX, ACT_SET_OWNER};
    w = rand_fields('0);
    w.key_hash = pool[$urandom_range(31)];
    r = $urandom_range(99);
    if (r < 40) begin
      w.action = ACT_INSERT;
    end else if (r < 75) begin
      w.action = acts[$urandom_range(6)];
      w = aim(w, 1'b0);
    end else if (r < 88) begin
      w.action = ACT_FIND_FIRST;
    end else begin
      // noise: any code, any cursor
      w.action = 4'($urandom_range(15));
      w.cursor_bucket = 8'($urandom());
      w.cursor_slot = 4'($urandom());
      if ($urandom_range(1)) w.key_hash = $urandom();
    end
    return w;
  endfunction

  // Words are built at the falling edge and driven at the rising edge
  task automatic send(int n, int mode);
    int       sent, burst, gap, idx;
    bit       go, v;
    in_word_t nxt;
    sent  = 0;
    burst = $urandom_range(1, 12);
    gap   = 0;
    while (sent < n || in_valid) begin
      @(negedge clk);
      go = !in_valid || !in_stall;
      v  = 1'b0;
      if (go) begin
        if (sent < n && gap == 0) begin
          idx = sent;
          case (mode)
            0: nxt = rand_word();
            1: nxt = dir_basic(idx);
            default: nxt = dir_full(idx);
          endcase
          v = 1'b1;
          sent++;
          burst--;
          if (mode == 1) gap = 1;
          if (burst == 0) begin
            burst = $urandom_range(1, 12);
            gap = ($urandom_range(7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
          end
        end else if (gap > 0) begin
          gap--;
        end
      end
      @(posedge clk);
      if (go) begin
        in_valid <= v;
        if (v) in_word <= nxt;
      end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending != 0 || in_valid) @(negedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic cfg_write(logic addr_idx, logic [LOAD_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {addr_idx, 2'b00};
    pwdata  <= CFG_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    pool[0] = 32'h0;
    pool[1] = 32'hffff_ffff;
    for (int k = 2; k < 32; k++) pool[k] = $urandom();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset loads
    send(20, 1);
    send(15, 0);
    wait_idle();

    // split threshold 16, equal to the slot count; merges off
    cfg_write(REG_HIGH, 5'd16);
    cfg_write(REG_LOW, 5'd0);
    send(18, 2);
    send(15, 0);
    wait_idle();

    // split once entries exceed buckets, merge while entries are below 16 per bucket
    cfg_write(REG_HIGH, 5'd1);
    cfg_write(REG_LOW, 5'd16);
    send(20, 0);
    wait_idle();

    cfg_write(REG_HIGH, 5'd2);
    cfg_write(REG_LOW, 5'd0);
    send(12, 0);
    wait_idle();

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### linear_hash_table_engine_core.f
hw/rtl/lhte_pkg.sv
hw/rtl/lhte_regs.sv
hw/rtl/lhte_out.sv
hw/rtl/lhte_ctrl.sv
hw/rtl/linear_hash_table_engine_core.sv
test/lhte_checker.sv
test/tb_linear_hash_table_engine_core.sv
